// ===== sv/ppts_pkg.sv =====
// Shared types, register codes and constants for the pure-pursuit target steering block.
package ppts_pkg;

    // Default sizing
    localparam int COORD_BITS_DEF = 24;
    localparam int MAX_POINTS_DEF = 1024;

    // Fixed field widths
    localparam int LA_W    = 20;
    localparam int GAIN_W  = 24;
    localparam int SPEED_W = 20;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W   = 10;
    localparam int STEER_W = 12;

    // Register reset values
    localparam logic [LA_W-1:0]    LOOKAHEAD_RST = LA_W'(4096);
    localparam logic [GAIN_W-1:0]  GAIN_RST      = GAIN_W'(131072);
    localparam logic [SPEED_W-1:0] SPEED_RST     = SPEED_W'(4096);

    // Steering clamp, 0.4 rad in 1/4096 rad
    localparam int STEER_LIMIT = 1638;
    // Q20.28 product down to 1/4096 rad
    localparam int STEER_SHIFT = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_UPDATE,
        ST_STEER_MUL,
        ST_STEER_OUT
    } ppts_state_t;

    // Handshake between sequencer and square-root unit
    typedef struct packed {
        logic load;
    } ppts_root_ctl_t;

    typedef struct packed {
        logic ready;
    } ppts_root_sts_t;

endpackage

// ===== sv/pure_pursuit_target_steer_unit.sv =====
// Top level: pure-pursuit lookahead target selection and steering command.
//
// Waypoints arrive one per start pulse, already in the vehicle frame (Q12.12 m),
// with last marking the end of a path. Each counted waypoint keeps busy high while
// it is squared on the shared multiplier, rooted and compared, so a new waypoint
// is taken only once busy falls; the square-root unit retires two bits of the
// squared distance per cycle. The last waypoint then runs the steering product on the
// shared multiplier, after which done pulses for exactly one cycle with found,
// target_index, steering and speed_out; the receiver cannot stall, so capture them
// in that cycle. Waypoints past MAX_POINTS in one path are not counted and leave
// busy low, though one with last set still ends the path. Configuration writes are
// taken at once and should be made only while the block is idle.
module pure_pursuit_target_steer_unit
    import ppts_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  way_x,
    input  logic signed [COORD_BITS-1:0]  way_y,
    input  logic                          last,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // Result
    output logic                          done,
    output logic                          found,
    output logic [IDX_W-1:0]              target_index,
    output logic signed [STEER_W-1:0]     steering,
    output logic [SPEED_W-1:0]            speed_out
);

    localparam int C     = COORD_BITS;
    localparam int MUL_W = (C > GAIN_W) ? C : GAIN_W;
    localparam int AW    = (C > LA_W) ? C : LA_W;
    localparam int PC_W  = $clog2(MAX_POINTS + 1);
    localparam int MAG_W = C + GAIN_W;
    localparam int Q_W   = MAG_W - STEER_SHIFT + 1;
    localparam int LIM_W = STEER_W - 1;

    // Configuration registers
    logic [LA_W-1:0]    lookahead_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] speed_reg;

    // Sequencer
    ppts_state_t state_reg, state_next;

    // Current item
    logic signed [C-1:0] x_reg;
    logic signed [C-1:0] y_reg;
    logic                last_reg;
    logic [C-1:0]        mx_reg;
    logic [C-1:0]        my_reg;
    logic [2*C-1:0]      sq_reg;

    // Run state
    logic [PC_W-1:0]     pc_reg;
    logic                fwd_valid_reg;
    logic [AW:0]         fwd_diff_reg;
    logic [IDX_W-1:0]    fwd_idx_reg;
    logic signed [C-1:0] fwd_y_reg;
    logic [AW:0]         rev_diff_reg;
    logic [IDX_W-1:0]    rev_idx_reg;
    logic signed [C-1:0] rev_y_reg;

    // Result registers
    logic                      done_reg;
    logic                      found_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [STEER_W-1:0] steer_reg;
    logic [SPEED_W-1:0]        speed_out_reg;

    // Shared units
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;
    ppts_root_ctl_t     root_ctl;
    ppts_root_sts_t     root_sts;
    logic [C-1:0]       root;

    logic                accept;
    logic                room;
    logic [C-1:0]        in_mx;
    logic [C-1:0]        in_my;

    logic signed [AW:0]  diff;
    logic [AW:0]         adiff;
    logic                fwd_take;
    logic                rev_take;
    logic [PC_W+IDX_W-1:0] pc_ext;

    logic                have_pick;
    logic signed [C-1:0] sel_y;
    logic [C-1:0]        sel_my;
    logic [IDX_W-1:0]    sel_idx;
    logic [MAG_W-1:0]    steer_mag;
    logic [Q_W-1:0]      q_raw;
    logic [LIM_W-1:0]    q_lim;
    logic signed [STEER_W-1:0] steer_val;

    ppts_mul #(
        .MUL_W (MUL_W)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    ppts_isqrt #(
        .ROOT_W (C)
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (root_ctl),
        .operand (sq_reg + mul_p[2*C-1:0]),
        .sts     (root_sts),
        .root    (root)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign room   = (pc_reg < PC_W'(MAX_POINTS));
    assign in_mx  = way_x[C-1] ? C'(-way_x) : C'(way_x);
    assign in_my  = way_y[C-1] ? C'(-way_y) : C'(way_y);

    // Compare the new distance against both running picks
    always_comb
    begin
        diff     = $signed({1'b0, AW'(root)}) - $signed({1'b0, AW'(lookahead_reg)});
        adiff    = diff[AW] ? (AW+1)'(-diff) : (AW+1)'(diff);
        fwd_take = !x_reg[C-1] && !diff[AW] && (diff != '0) &&
                   ((AW+1)'(diff) < fwd_diff_reg);
        rev_take = (adiff < rev_diff_reg);
        pc_ext   = {{IDX_W{1'b0}}, pc_reg};
    end

    // Pick the winner and shape the steering value
    always_comb
    begin
        have_pick = fwd_valid_reg || (pc_reg != '0);
        sel_y     = fwd_valid_reg ? fwd_y_reg : rev_y_reg;
        sel_idx   = fwd_valid_reg ? fwd_idx_reg : rev_idx_reg;
        sel_my    = sel_y[C-1] ? C'(-sel_y) : C'(sel_y);
        steer_mag = mul_p[MAG_W-1:0];
        if (sel_y[C-1])
        begin
            q_raw = Q_W'(({1'b0, steer_mag} + (MAG_W+1)'((1 << STEER_SHIFT) - 1))
                         >> STEER_SHIFT);
        end
        else
        begin
            q_raw = Q_W'(steer_mag >> STEER_SHIFT);
        end
        if (q_raw > Q_W'(STEER_LIMIT))
        begin
            q_lim = LIM_W'(STEER_LIMIT);
        end
        else
        begin
            q_lim = q_raw[LIM_W-1:0];
        end
        if (!have_pick)
        begin
            steer_val = '0;
        end
        else if (sel_y[C-1])
        begin
            steer_val = -$signed({1'b0, q_lim});
        end
        else
        begin
            steer_val = $signed({1'b0, q_lim});
        end
    end

    // Next state and shared-unit operands
    always_comb
    begin
        state_next    = state_reg;
        mul_a         = '0;
        mul_b         = '0;
        root_ctl.load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (room)
                    begin
                        state_next = ST_SQ_X;
                    end
                    else if (last)
                    begin
                        state_next = ST_STEER_MUL;
                    end
                end
            end
            ST_SQ_X:
            begin
                mul_a      = MUL_W'(mx_reg);
                mul_b      = MUL_W'(mx_reg);
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                mul_a      = MUL_W'(my_reg);
                mul_b      = MUL_W'(my_reg);
                state_next = ST_ROOT_LOAD;
            end
            ST_ROOT_LOAD:
            begin
                root_ctl.load = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_sts.ready)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = last_reg ? ST_STEER_MUL : ST_IDLE;
            end
            ST_STEER_MUL:
            begin
                mul_a      = MUL_W'(sel_my);
                mul_b      = MUL_W'(gain_reg);
                state_next = ST_STEER_OUT;
            end
            ST_STEER_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg <= LOOKAHEAD_RST;
            gain_reg      <= GAIN_RST;
            speed_reg     <= SPEED_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOOKAHEAD: lookahead_reg <= cfg_data[LA_W-1:0];
                CFG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                CFG_SPEED:     speed_reg     <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    // Capture the item and the first square
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= way_x;
            y_reg    <= way_y;
            last_reg <= last;
            mx_reg   <= in_mx;
            my_reg   <= in_my;
        end
        if (state_reg == ST_SQ_Y)
        begin
            sq_reg <= mul_p[2*C-1:0];
        end
    end

    // Run state: update picks, clear after the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_diff_reg  <= '1;
            fwd_idx_reg   <= '0;
            fwd_y_reg     <= '0;
            rev_diff_reg  <= '1;
            rev_idx_reg   <= '0;
            rev_y_reg     <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            if (fwd_take)
            begin
                fwd_valid_reg <= 1'b1;
                fwd_diff_reg  <= (AW+1)'(diff);
                fwd_idx_reg   <= pc_ext[IDX_W-1:0];
                fwd_y_reg     <= y_reg;
            end
            if (rev_take)
            begin
                rev_diff_reg <= adiff;
                rev_idx_reg  <= pc_ext[IDX_W-1:0];
                rev_y_reg    <= y_reg;
            end
            pc_reg <= pc_reg + 1'b1;
        end
        else if (state_reg == ST_STEER_OUT)
        begin
            pc_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_diff_reg  <= '1;
            fwd_idx_reg   <= '0;
            fwd_y_reg     <= '0;
            rev_diff_reg  <= '1;
            rev_idx_reg   <= '0;
            rev_y_reg     <= '0;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_STEER_OUT);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STEER_OUT)
        begin
            found_reg     <= have_pick;
            idx_reg       <= have_pick ? sel_idx : '0;
            steer_reg     <= steer_val;
            speed_out_reg <= speed_reg;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign found        = found_reg;
    assign target_index = idx_reg;
    assign steering     = steer_reg;
    assign speed_out    = speed_out_reg;

`ifndef SYNTHESIS
    // A path yields one result, never two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // No pick means a zero index and zero steering
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (target_index == '0 && steering == '0))
        else $error("empty result carries index or steering");

    // Steering stays inside the clamp
    a_steer_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(steering) <= $signed(STEER_W'(STEER_LIMIT)) &&
                  $signed(steering) >= -$signed(STEER_W'(STEER_LIMIT))))
        else $error("steering outside clamp");

    // Point counter saturates at the path limit
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_W'(MAX_POINTS))
        else $error("point counter past limit");
`endif

endmodule

// ===== sv/ppts_mul.sv =====
// Shared unsigned multiplier with a registered product.
module ppts_mul
    import ppts_pkg::*;
#(
    parameter int MUL_W = 32
)
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     op_a,
    input  logic [MUL_W-1:0]     op_b,
    output logic [2*MUL_W-1:0]   prod
);

    logic [2*MUL_W-1:0] prod_reg;

    // Register every product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/ppts_isqrt.sv =====
// Iterative integer square root, two operand bits per cycle.
module ppts_isqrt
    import ppts_pkg::*;
#(
    parameter int ROOT_W = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ppts_root_ctl_t         ctl,
    input  logic [2*ROOT_W-1:0]    operand,
    output ppts_root_sts_t         sts,
    output logic [ROOT_W-1:0]      root
);

    localparam int SUM_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SUM_W-1:0]  sum_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    // One restoring step: bring down two bits, try root*4+1
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], sum_reg[SUM_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        take      = (rem_shift >= trial);
    end

    // Control: step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            cnt_reg <= CNT_W'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Datapath: load operand, then advance one digit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sum_reg  <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            sum_reg <= {sum_reg[SUM_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign sts.ready = (cnt_reg == '0);
    assign root      = root_reg;

endmodule
